@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the status LED sequencer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SLPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// Check that a condition never holds outside reset.
`define SLPS_NEVER(label, clk, rst_n, cond) \
    `SLPS_ASSERT(label, clk, rst_n, !(cond))

`endif

@@ rtl/core/slps_pkg.sv @@
// Shared types and constants of the status LED pattern sequencer.
// No dependencies; used by every module of the block.
package slps_pkg;

    localparam int TIME_W = 17;
    localparam logic [TIME_W-1:0] TIME_MAX = 17'h1FFFF;

    // Input kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_PROG = 2'd2;

    // Modes
    localparam logic [2:0] MODE_BOOT     = 3'd0;
    localparam logic [2:0] MODE_DISARMED = 3'd1;
    localparam logic [2:0] MODE_ARMED    = 3'd2;
    localparam logic [2:0] MODE_ALARM    = 3'd3;
    localparam logic [2:0] MODE_LINK     = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_DARK_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_CHASE_PERIOD = 3'd1;
    localparam logic [2:0] REG_STEADY       = 3'd2;
    localparam logic [2:0] REG_PULSE_PERIOD = 3'd3;
    localparam logic [2:0] REG_ALARM_BLINK  = 3'd4;
    localparam logic [2:0] REG_LINK_BLINK   = 3'd5;

    localparam logic [16:0] RST_DARK_TIMEOUT = 17'd60000;
    localparam logic [15:0] RST_CHASE_PERIOD = 16'd100;
    localparam logic [15:0] RST_STEADY       = 16'd1000;
    localparam logic [15:0] RST_PULSE_PERIOD = 16'd30;
    localparam logic [15:0] RST_ALARM_BLINK  = 16'd100;
    localparam logic [15:0] RST_LINK_BLINK   = 16'd500;

    // Pulse levels
    localparam logic [7:0] PULSE_STEP    = 8'd5;
    localparam logic [7:0] PULSE_LOW     = 8'd10;
    localparam logic [7:0] PULSE_HIGH    = 8'd150;
    localparam logic [7:0] PULSE_START   = 8'd50;
    localparam logic [7:0] PULSE_UP_LIM  = 8'd250;
    localparam logic [7:0] LEVEL_FULL    = 8'd255;
    localparam logic [7:0] LEVEL_AMBER_G = 8'd200;

    localparam int PROG_FULL = 100;

    typedef struct packed {
        logic [16:0] dark_timeout_ms;
        logic [15:0] chase_period_ms;
        logic [15:0] steady_refresh_ms;
        logic [15:0] pulse_period_ms;
        logic [15:0] alarm_blink_ms;
        logic [15:0] link_blink_ms;
    } t_cfg;

    // One frame: pixels with lit_lo <= index < lit_hi take the colour, others are off
    typedef struct packed {
        logic [3:0] lit_lo;
        logic [3:0] lit_hi;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd;

    localparam int QUEUE_DEPTH = 2;

endpackage

@@ rtl/core/status_led_pattern_sequencer.sv @@
// Top level of the status LED pattern sequencer: register file, front end, queue, emitter.
// Depends on slps_pkg, slps_front, slps_queue and slps_back.
//
// Use: items arrive on the s_axis channel, one beat per item. tuser carries the kind
// (tick, mode change, progress); tdata carries the new mode and the progress percent.
// Each item that redraws the strip yields one frame of PIXEL_COUNT beats on m_axis,
// pixel 0 first, with tlast on the final pixel. Items that redraw nothing yield no beat.
// An item's frame is written into the queue and then loaded into the emitter once it is
// free. Throughput: one item per cycle is taken while the queue has room; frames leave
// at one pixel per cycle while the receiver is ready, so a stream of redrawing items is
// limited by the single pixel emitter.
// A two-entry frame queue separates intake from output: items keep being taken while a
// pixel waits on a stalled receiver, until two frames are queued; then s_axis_tready drops.
// Stalling m_axis holds the current pixel beat and loses nothing.
// Reset (synchronous, active low) selects boot mode, clears both timers, the chase
// position, pulse level and blink phase, sets the pulse rising, empties the queue and
// loads every timing register with its default. The APB port writes the timing registers
// (byte address 4 * index) and reads them back; writes are meant for idle periods only.
`include "assert_macros.svh"

module status_led_pattern_sequencer #(
    parameter int PIXEL_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] new_mode, [9:3] progress_percent, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // pixel channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [2:0] pixel_index, [10:3] red, [18:11] green,
                                        // [26:19] blue, rest zero
    output logic        m_axis_tlast,   // last_pixel
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    slps_pkg::t_cfg r_cfg;
    logic [2:0]     w_reg_idx;
    logic           w_wr;

    logic           w_push;
    slps_pkg::t_cmd w_push_cmd;
    logic           w_full;
    logic           w_pop;
    logic           w_q_valid;
    slps_pkg::t_cmd w_q_cmd;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_wr      = psel && penable && pwrite && pready;

    // Register file: write on the access beat, ignore indexes past the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_timeout_ms   <= slps_pkg::RST_DARK_TIMEOUT;
            r_cfg.chase_period_ms   <= slps_pkg::RST_CHASE_PERIOD;
            r_cfg.steady_refresh_ms <= slps_pkg::RST_STEADY;
            r_cfg.pulse_period_ms   <= slps_pkg::RST_PULSE_PERIOD;
            r_cfg.alarm_blink_ms    <= slps_pkg::RST_ALARM_BLINK;
            r_cfg.link_blink_ms     <= slps_pkg::RST_LINK_BLINK;
        end else if (w_wr) begin
            case (w_reg_idx)
                slps_pkg::REG_DARK_TIMEOUT: r_cfg.dark_timeout_ms   <= pwdata[16:0];
                slps_pkg::REG_CHASE_PERIOD: r_cfg.chase_period_ms   <= pwdata[15:0];
                slps_pkg::REG_STEADY:       r_cfg.steady_refresh_ms <= pwdata[15:0];
                slps_pkg::REG_PULSE_PERIOD: r_cfg.pulse_period_ms   <= pwdata[15:0];
                slps_pkg::REG_ALARM_BLINK:  r_cfg.alarm_blink_ms    <= pwdata[15:0];
                slps_pkg::REG_LINK_BLINK:   r_cfg.link_blink_ms     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read back; unused addresses return zero
    always_comb begin
        case (w_reg_idx)
            slps_pkg::REG_DARK_TIMEOUT: prdata = 32'(r_cfg.dark_timeout_ms);
            slps_pkg::REG_CHASE_PERIOD: prdata = 32'(r_cfg.chase_period_ms);
            slps_pkg::REG_STEADY:       prdata = 32'(r_cfg.steady_refresh_ms);
            slps_pkg::REG_PULSE_PERIOD: prdata = 32'(r_cfg.pulse_period_ms);
            slps_pkg::REG_ALARM_BLINK:  prdata = 32'(r_cfg.alarm_blink_ms);
            slps_pkg::REG_LINK_BLINK:   prdata = 32'(r_cfg.link_blink_ms);
            default:                    prdata = 32'd0;
        endcase
    end

    // Classify items and advance the animation state
    slps_front #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_new_mode (s_axis_tdata[2:0]),
        .i_percent  (s_axis_tdata[9:3]),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_full     (w_full)
    );

    // Hold up to two pending frames
    slps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Emit one beat per pixel
    slps_back #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    // A frame is only taken from the queue when one is waiting there
    `SLPS_NEVER(a_pop_needs_frame, i_clk, i_rst_n, w_pop && !w_q_valid)

endmodule

@@ rtl/core/slps_front.sv @@
// Front end: accepts input items, advances the sequencer state and issues frame commands.
// Depends on slps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slps_front #(
    parameter int PIXEL_COUNT = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slps_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [2:0]        i_new_mode,
    input  logic [6:0]        i_percent,
    output logic              o_push,
    output slps_pkg::t_cmd    o_cmd,
    input  logic              i_full
);

    logic [2:0]  r_mode,      n_mode;
    logic [16:0] r_since_ref, n_since_ref;
    logic [16:0] r_since_mc,  n_since_mc;
    logic [2:0]  r_chase,     n_chase;
    logic [7:0]  r_level,     n_level;
    logic        r_rising,    n_rising;
    logic        r_phase,     n_phase;

    logic        w_accept;
    logic        w_emit;
    logic [16:0] w_ref_inc;
    logic [16:0] w_mc_inc;
    logic [9:0]  w_prod;
    logic [3:0]  w_lit;
    logic [7:0]  w_lvl;
    slps_pkg::t_cmd w_cmd;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && w_emit;
    assign o_cmd    = w_cmd;

    assign w_ref_inc = (r_since_ref == slps_pkg::TIME_MAX) ? r_since_ref : r_since_ref + 17'd1;
    assign w_mc_inc  = (r_since_mc == slps_pkg::TIME_MAX) ? r_since_mc : r_since_mc + 17'd1;
    assign w_prod    = 10'(i_percent) * 10'(PIXEL_COUNT);

    // Lit count of a progress frame: compare against each multiple of one hundred
    always_comb begin
        w_lit = 4'd0;
        for (int k = 1; k <= PIXEL_COUNT; k++) begin
            if (w_prod >= 10'(slps_pkg::PROG_FULL * k)) begin
                w_lit = 4'(k);
            end
        end
    end

    // Next pulse level
    always_comb begin
        if (r_rising) begin
            w_lvl = (r_level > slps_pkg::PULSE_UP_LIM) ? slps_pkg::LEVEL_FULL
                                                       : r_level + slps_pkg::PULSE_STEP;
        end else begin
            w_lvl = (r_level < slps_pkg::PULSE_STEP) ? 8'd0 : r_level - slps_pkg::PULSE_STEP;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_since_ref = r_since_ref;
        n_since_mc  = r_since_mc;
        n_chase     = r_chase;
        n_level     = r_level;
        n_rising    = r_rising;
        n_phase     = r_phase;
        w_emit      = 1'b0;
        w_cmd       = '{lit_lo: 4'd0, lit_hi: 4'(PIXEL_COUNT),
                        red: 8'd0, green: 8'd0, blue: 8'd0};
        case (i_kind)
            slps_pkg::KIND_TICK: begin
                n_since_ref = w_ref_inc;
                n_since_mc  = w_mc_inc;
                case (r_mode)
                    slps_pkg::MODE_BOOT: begin
                        if (w_ref_inc > 17'(i_cfg.chase_period_ms)) begin
                            n_since_ref  = 17'd0;
                            w_emit       = 1'b1;
                            w_cmd.lit_lo = {1'b0, r_chase};
                            w_cmd.lit_hi = {1'b0, r_chase} + 4'd1;
                            w_cmd.blue   = slps_pkg::LEVEL_FULL;
                            n_chase      = (r_chase == 3'(PIXEL_COUNT - 1)) ? 3'd0
                                                                            : r_chase + 3'd1;
                        end
                    end
                    slps_pkg::MODE_DISARMED: begin
                        if (w_mc_inc > i_cfg.dark_timeout_ms) begin
                            w_emit = 1'b1;
                        end else if (w_ref_inc > 17'(i_cfg.steady_refresh_ms)) begin
                            n_since_ref = 17'd0;
                            w_emit      = 1'b1;
                            w_cmd.green = slps_pkg::LEVEL_FULL;
                        end
                    end
                    slps_pkg::MODE_ARMED: begin
                        if (w_ref_inc > 17'(i_cfg.pulse_period_ms)) begin
                            n_since_ref = 17'd0;
                            w_emit      = 1'b1;
                            n_level     = w_lvl;
                            if (w_lvl <= slps_pkg::PULSE_LOW || w_lvl >= slps_pkg::PULSE_HIGH) begin
                                n_rising = !r_rising;
                            end
                            w_cmd.red  = w_lvl;
                            w_cmd.blue = {1'b0, w_lvl[7:1]};
                        end
                    end
                    slps_pkg::MODE_ALARM: begin
                        if (w_ref_inc > 17'(i_cfg.alarm_blink_ms)) begin
                            n_since_ref = 17'd0;
                            w_emit      = 1'b1;
                            n_phase     = !r_phase;
                            if (!r_phase) begin
                                w_cmd.red  = slps_pkg::LEVEL_FULL;
                            end else begin
                                w_cmd.blue = slps_pkg::LEVEL_FULL;
                            end
                        end
                    end
                    slps_pkg::MODE_LINK: begin
                        if (w_ref_inc > 17'(i_cfg.link_blink_ms)) begin
                            n_since_ref = 17'd0;
                            w_emit      = 1'b1;
                            n_phase     = !r_phase;
                            if (!r_phase) begin
                                w_cmd.red   = slps_pkg::LEVEL_FULL;
                                w_cmd.green = slps_pkg::LEVEL_AMBER_G;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            slps_pkg::KIND_MODE: begin
                if (i_new_mode <= slps_pkg::MODE_LINK) begin
                    n_mode     = i_new_mode;
                    n_since_mc = 17'd0;
                    n_level    = slps_pkg::PULSE_START;
                    w_emit     = 1'b1;
                end
            end
            slps_pkg::KIND_PROG: begin
                w_emit       = 1'b1;
                w_cmd.lit_hi = w_lit;
                w_cmd.green  = slps_pkg::LEVEL_FULL;
                w_cmd.blue   = (i_percent >= 7'(slps_pkg::PROG_FULL)) ? 8'd0
                                                                      : slps_pkg::LEVEL_FULL;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= slps_pkg::MODE_BOOT;
            r_since_ref <= 17'd0;
            r_since_mc  <= 17'd0;
            r_chase     <= 3'd0;
            r_level     <= 8'd0;
            r_rising    <= 1'b1;
            r_phase     <= 1'b0;
        end else if (w_accept) begin
            r_mode      <= n_mode;
            r_since_ref <= n_since_ref;
            r_since_mc  <= n_since_mc;
            r_chase     <= n_chase;
            r_level     <= n_level;
            r_rising    <= n_rising;
            r_phase     <= n_phase;
        end
    end

    // A valid mode change restarts the mode timer and the pulse level
    `SLPS_ASSERT(a_mode_change_restart, i_clk, i_rst_n,
        (w_accept && i_kind == slps_pkg::KIND_MODE && i_new_mode <= slps_pkg::MODE_LINK)
        |=> (r_since_mc == 17'd0 && r_level == slps_pkg::PULSE_START))

endmodule

@@ rtl/core/slps_queue.sv @@
// Short command queue between the front end and the pixel emitter.
// Depends on slps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slps_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output slps_pkg::t_cmd o_cmd
);

    localparam int DEPTH = slps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slps_pkg::t_cmd   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slot[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SLPS_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && o_full)
    `SLPS_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))

endmodule

@@ rtl/core/slps_back.sv @@
// Back end: expands one frame command into one beat per pixel with a registered index.
// Depends on slps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slps_back #(
    parameter int PIXEL_COUNT = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  slps_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_data,
    output logic           o_last
);

    logic           r_busy;
    logic [2:0]     r_idx;
    slps_pkg::t_cmd r_cmd;
    logic           w_beat;
    logic           w_lit;

    assign o_valid = r_busy;
    assign o_last  = (r_idx == 3'(PIXEL_COUNT - 1));
    assign w_beat  = r_busy && i_ready;
    assign o_pop   = i_cmd_valid && (!r_busy || (w_beat && o_last));
    assign w_lit   = ({1'b0, r_idx} >= r_cmd.lit_lo) && ({1'b0, r_idx} < r_cmd.lit_hi);

    // bits: index, red, green, blue, zero pad
    assign o_data = {5'd0,
                     w_lit ? r_cmd.blue  : 8'd0,
                     w_lit ? r_cmd.green : 8'd0,
                     w_lit ? r_cmd.red   : 8'd0,
                     r_idx};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (w_beat) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // A taken beat that is not the last one moves to the next pixel
    `SLPS_ASSERT(a_pixel_advance, i_clk, i_rst_n,
        (w_beat && !o_last) |=> (r_busy && r_idx == $past(r_idx) + 3'd1))

endmodule

@@ sim/status_led_pattern_sequencer_tb.sv @@
// Self-checking testbench for the status LED pattern sequencer: a strip tracker class
// predicts every pixel beat; tasks drive the item stream, the APB port and the receiver.
// Depends on slps_pkg and the status_led_pattern_sequencer RTL only.
`timescale 1ns / 1ps

package led_strip_check_pkg;

    localparam int PIXELS = 6;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_led_pixel;

    // Tracks the animator state and queues the pixels each accepted item must produce.
    class t_led_strip_tracker;
        slps_pkg::t_cfg regs;
        logic [2:0]     mode;
        logic [16:0]    since_refresh;
        logic [16:0]    since_mode;
        int unsigned    chase_pos;
        logic [7:0]     level;
        bit             rising;
        bit             phase;
        t_led_pixel     pending_pixels[$];
        int unsigned    fail_count;

        function new();
            regs.dark_timeout_ms   = slps_pkg::RST_DARK_TIMEOUT;
            regs.chase_period_ms   = slps_pkg::RST_CHASE_PERIOD;
            regs.steady_refresh_ms = slps_pkg::RST_STEADY;
            regs.pulse_period_ms   = slps_pkg::RST_PULSE_PERIOD;
            regs.alarm_blink_ms    = slps_pkg::RST_ALARM_BLINK;
            regs.link_blink_ms     = slps_pkg::RST_LINK_BLINK;
            mode          = slps_pkg::MODE_BOOT;
            since_refresh = '0;
            since_mode    = '0;
            chase_pos     = 0;
            level         = '0;
            rising        = 1'b1;
            phase         = 1'b0;
            fail_count    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                slps_pkg::REG_DARK_TIMEOUT: regs.dark_timeout_ms   = value[16:0];
                slps_pkg::REG_CHASE_PERIOD: regs.chase_period_ms   = value[15:0];
                slps_pkg::REG_STEADY:       regs.steady_refresh_ms = value[15:0];
                slps_pkg::REG_PULSE_PERIOD: regs.pulse_period_ms   = value[15:0];
                slps_pkg::REG_ALARM_BLINK:  regs.alarm_blink_ms    = value[15:0];
                slps_pkg::REG_LINK_BLINK:   regs.link_blink_ms     = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                slps_pkg::REG_DARK_TIMEOUT: return {15'd0, regs.dark_timeout_ms};
                slps_pkg::REG_CHASE_PERIOD: return {16'd0, regs.chase_period_ms};
                slps_pkg::REG_STEADY:       return {16'd0, regs.steady_refresh_ms};
                slps_pkg::REG_PULSE_PERIOD: return {16'd0, regs.pulse_period_ms};
                slps_pkg::REG_ALARM_BLINK:  return {16'd0, regs.alarm_blink_ms};
                slps_pkg::REG_LINK_BLINK:   return {16'd0, regs.link_blink_ms};
                default:                    return '0;
            endcase
        endfunction

        // Pixels in [first, stop) take the colour, the rest are off.
        function void paint(int unsigned first, int unsigned stop,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_led_pixel px;
            for (int unsigned i = 0; i < PIXELS; i++) begin
                px.index = i[2:0];
                px.last  = (i == PIXELS - 1);
                if (i >= first && i < stop) begin
                    px.red = r; px.green = g; px.blue = b;
                end else begin
                    px.red = '0; px.green = '0; px.blue = '0;
                end
                pending_pixels.push_back(px);
            end
        endfunction

        function bit refresh_due(logic [16:0] period);
            if (since_refresh > period) begin
                since_refresh = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void advance_ms();
            if (since_refresh != slps_pkg::TIME_MAX) since_refresh++;
            if (since_mode != slps_pkg::TIME_MAX) since_mode++;
            case (mode)
                slps_pkg::MODE_BOOT: if (refresh_due(17'(regs.chase_period_ms))) begin
                    paint(chase_pos, chase_pos + 1, 8'd0, 8'd0, slps_pkg::LEVEL_FULL);
                    chase_pos = (chase_pos + 1) % PIXELS;
                end
                slps_pkg::MODE_DISARMED: begin
                    // dark holds the refresh timer, so it keeps counting
                    if (since_mode > regs.dark_timeout_ms)
                        paint(0, PIXELS, 8'd0, 8'd0, 8'd0);
                    else if (refresh_due(17'(regs.steady_refresh_ms)))
                        paint(0, PIXELS, 8'd0, slps_pkg::LEVEL_FULL, 8'd0);
                end
                slps_pkg::MODE_ARMED: if (refresh_due(17'(regs.pulse_period_ms))) begin
                    if (rising)
                        level = (level > slps_pkg::PULSE_UP_LIM) ? slps_pkg::LEVEL_FULL
                                                                 : level + slps_pkg::PULSE_STEP;
                    else
                        level = (level < slps_pkg::PULSE_STEP) ? 8'd0
                                                               : level - slps_pkg::PULSE_STEP;
                    if (level <= slps_pkg::PULSE_LOW || level >= slps_pkg::PULSE_HIGH)
                        rising = !rising;
                    paint(0, PIXELS, level, 8'd0, level >> 1);
                end
                slps_pkg::MODE_ALARM: if (refresh_due(17'(regs.alarm_blink_ms))) begin
                    phase = !phase;
                    if (phase) paint(0, PIXELS, slps_pkg::LEVEL_FULL, 8'd0, 8'd0);
                    else       paint(0, PIXELS, 8'd0, 8'd0, slps_pkg::LEVEL_FULL);
                end
                slps_pkg::MODE_LINK: if (refresh_due(17'(regs.link_blink_ms))) begin
                    phase = !phase;
                    if (phase) paint(0, PIXELS, slps_pkg::LEVEL_FULL, slps_pkg::LEVEL_AMBER_G,
                                     8'd0);
                    else       paint(0, PIXELS, 8'd0, 8'd0, 8'd0);
                end
                default: ;
            endcase
        endfunction

        function void take_item(logic [1:0] kind, logic [2:0] nm, logic [6:0] pct);
            int unsigned lit;
            case (kind)
                slps_pkg::KIND_TICK: advance_ms();
                slps_pkg::KIND_MODE: if (nm <= slps_pkg::MODE_LINK) begin
                    mode       = nm;
                    since_mode = '0;
                    level      = slps_pkg::PULSE_START;
                    paint(0, PIXELS, 8'd0, 8'd0, 8'd0);
                end
                slps_pkg::KIND_PROG: begin
                    lit = int'(pct) * PIXELS / slps_pkg::PROG_FULL;
                    if (lit > PIXELS) lit = PIXELS;
                    paint(0, lit, 8'd0, slps_pkg::LEVEL_FULL,
                          (pct >= slps_pkg::PROG_FULL) ? 8'd0 : slps_pkg::LEVEL_FULL);
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_pixel(logic [31:0] tdata, logic tlast);
            t_led_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with no frame pending: tdata %h", tdata);
                fail_count++;
                return;
            end
            want = pending_pixels.pop_front();
            compare("pixel_index", 32'(want.index), 32'(tdata[2:0]));
            compare("red",         32'(want.red),   32'(tdata[10:3]));
            compare("green",       32'(want.green), 32'(tdata[18:11]));
            compare("blue",        32'(want.blue),  32'(tdata[26:19]));
            compare("pad",         0,               32'(tdata[31:27]));
            compare("last_pixel",  32'(want.last),  32'(tlast));
        endfunction
    endclass
endpackage

module status_led_pattern_sequencer_tb;

    // Codes the package leaves out: the spare kind and the unused mode numbers
    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    localparam int unsigned SETTLE      = 12;    // covers intake, queue and emitter latency
    localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no beat before giving up
    localparam int unsigned PHASE_ITEMS = 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [2:0] new_mode, [9:3] progress_percent, rest zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [2:0] index, [10:3] red, [18:11] green, [26:19] blue
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_strip_check_pkg::t_led_strip_tracker tracker;
    int unsigned      src_idle_pct = 0;
    int unsigned      sink_stall_pct = 0;
    int unsigned      quiet_cycles = 0;

    status_led_pattern_sequencer #(.PIXEL_COUNT(led_strip_check_pkg::PIXELS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Pixel receiver: stall at random, check every beat taken and feed the watchdog.
    // Values are sampled at the edge, so they are the ones held through the cycle before.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles  <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_pixel(m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if the block stops moving beats
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no beat accepted for %0d cycles, %0d pixels outstanding",
               QUIET_LIMIT, tracker.pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic set_pace(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Offer one item and hold it until taken. tvalid stays high on return so that a
    // following item goes out back to back; idle gaps and drain() lower it.
    task automatic send_item(input logic [1:0] kind, input logic [2:0] nm,
                             input logic [6:0] pct);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, pct, nm};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_item(kind, nm, pct);
    endtask

    // Hold the sender until every predicted pixel has left, then let the pipe settle
    task automatic drain(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] back;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (back !== tracker.reg_value(idx)) begin
            $error("register %0d mismatch: expected %0d, got %0d",
                   idx, tracker.reg_value(idx), back);
            tracker.fail_count++;
        end
    endtask

    // Write a register, mirror it in the tracker and read it back
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        tracker.set_reg(idx, value);
        check_reg(idx);
    endtask

    task automatic set_timing(input logic [31:0] dark, input logic [31:0] chase,
                              input logic [31:0] steady, input logic [31:0] pulse,
                              input logic [31:0] alarm, input logic [31:0] link);
        program_reg(slps_pkg::REG_DARK_TIMEOUT, dark);
        program_reg(slps_pkg::REG_CHASE_PERIOD, chase);
        program_reg(slps_pkg::REG_STEADY, steady);
        program_reg(slps_pkg::REG_PULSE_PERIOD, pulse);
        program_reg(slps_pkg::REG_ALARM_BLINK, alarm);
        program_reg(slps_pkg::REG_LINK_BLINK, link);
    endtask

    // Mostly well-formed runs: a mode change then a stretch of ticks, with the odd
    // progress value. Long stretches let the armed pulse reach both turning points.
    // Ignored items (spare kind, unused modes) are sprinkled in but not counted.
    task automatic run_random(input int unsigned target);
        int unsigned sent;
        int unsigned run_len;
        int unsigned pick;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_item(slps_pkg::KIND_MODE, 3'($urandom_range(slps_pkg::MODE_LINK)),
                          7'($urandom_range(127)));
                run_len = ($urandom_range(4) == 0) ? $urandom_range(45, 20)
                                                   : $urandom_range(12, 1);
                repeat (run_len) begin
                    if ($urandom_range(9) == 0)
                        send_item(slps_pkg::KIND_PROG, 3'($urandom_range(7)),
                                  7'($urandom_range(127)));
                    else
                        send_item(slps_pkg::KIND_TICK, 3'($urandom_range(7)),
                                  7'($urandom_range(127)));
                end
                sent += run_len + 1;
            end else if (pick < 85) begin
                send_item(slps_pkg::KIND_PROG, 3'($urandom_range(7)),
                          7'($urandom_range(127)));
                sent++;
            end else if (pick < 92) begin
                send_item(KIND_SPARE, 3'($urandom_range(7)), 7'($urandom_range(127)));
            end else begin
                send_item(slps_pkg::KIND_MODE,
                          3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)),
                          7'($urandom_range(127)));
            end
            // once per phase, hold the sender until the strip has caught up
            if (!paused && sent >= target / 2) begin
                drain(0);
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        tracker = new();
        set_pace(22, 84);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every register must come out of reset at its default
        for (int r = slps_pkg::REG_DARK_TIMEOUT; r <= slps_pkg::REG_LINK_BLINK; r++)
            check_reg(r[2:0]);

        // Directed part: short periods so that each mode redraws within a few ticks,
        // the chase period at zero so it steps on every tick.
        set_timing(3, 0, 1, 0, 0, 1);
        send_item(slps_pkg::KIND_TICK, 3'h7, 7'h7F);
        send_item(slps_pkg::KIND_TICK, 3'h0, 7'h00);
        send_item(slps_pkg::KIND_PROG, 3'h0, 7'd0);
        send_item(slps_pkg::KIND_PROG, 3'h7, 7'd16);    // just short of the first lit pixel
        send_item(slps_pkg::KIND_PROG, 3'h0, 7'd17);
        send_item(slps_pkg::KIND_PROG, 3'h0, 7'd99);
        send_item(slps_pkg::KIND_PROG, 3'h0, 7'd100);   // full bar turns green
        send_item(slps_pkg::KIND_PROG, 3'h0, 7'h7F);    // above full: saturate, still green
        send_item(slps_pkg::KIND_MODE, MODE_UNUSED_LO, 7'h00);
        send_item(slps_pkg::KIND_MODE, MODE_UNUSED_HI, 7'h7F);
        send_item(KIND_SPARE, 3'h7, 7'h7F);
        send_item(slps_pkg::KIND_MODE, slps_pkg::MODE_DISARMED, 7'h00);
        // green, then dark past timeout
        repeat (5) send_item(slps_pkg::KIND_TICK, 3'h0, 7'h00);
        send_item(slps_pkg::KIND_MODE, slps_pkg::MODE_ARMED, 7'h55);
        repeat (2) send_item(slps_pkg::KIND_TICK, 3'h5, 7'h2A);
        send_item(slps_pkg::KIND_MODE, slps_pkg::MODE_ALARM, 7'h2A);
        repeat (2) send_item(slps_pkg::KIND_TICK, 3'h2, 7'h55);
        send_item(slps_pkg::KIND_MODE, slps_pkg::MODE_LINK, 7'h7F);
        repeat (2) send_item(slps_pkg::KIND_TICK, 3'h7, 7'h00);

        // Random phases: each one changes the pace and the timing set
        for (int p = 0; p < 3; p++) begin
            drain(SETTLE);
            case (p)
                0: begin
                    set_pace(22, 84);
                    set_timing(0, 0, 0, 0, 0, 0);       // redraw on every tick, dark at once
                end
                1: begin
                    set_pace(84, 22);
                    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                default: begin
                    set_pace(0, 0);
                    set_timing($urandom_range(40), $urandom_range(6), $urandom_range(6),
                               $urandom_range(6), $urandom_range(6), $urandom_range(6));
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        drain(SETTLE);
        if (tracker.fail_count == 0 && tracker.pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
